FILE: hdl/small_key_value_table_macros.svh
// -----------------------------------------------------------------------------
// small_key_value_table_macros: assertion helpers for the key-value table
// Wraps concurrent assertions on clk_i with and without the reset guard.
// -----------------------------------------------------------------------------
`ifndef SMALL_KEY_VALUE_TABLE_MACROS_SVH
`define SMALL_KEY_VALUE_TABLE_MACROS_SVH

// Check a property on every rising edge of clk_i, skipped while rst_ni is low.
`define SKVT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising edge of clk_i, during reset as well.
`define SKVT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hdl/skvt_pkg.sv
// -----------------------------------------------------------------------------
// skvt_pkg: shared types for the small key-value table
// Request and status codes, and the control bundle driven into each cell.
// -----------------------------------------------------------------------------
package skvt_pkg;

  // Request kinds carried in the input tuser
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } skvt_op_e;

  // Result status codes carried in the output tuser
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } skvt_status_e;

  // Per-cell control from the table controller
  typedef struct packed {
    logic live;     // cell index is below the entry count
    logic capture;  // item accepted: register the key compare
    logic shift;    // take the upper neighbor's entry
    logic load;     // take the request's key and value
  } skvt_cell_ctrl_t;

endpackage

FILE: hdl/skvt_cell.sv
// -----------------------------------------------------------------------------
// skvt_cell: one slot of the key-value table
// Holds a key and value, compares the key against an accepted request and
// moves its entry down the row on delete.
// -----------------------------------------------------------------------------
module skvt_cell
  import skvt_pkg::*;
#(
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  skvt_cell_ctrl_t       ctrl_i,
  input  logic [KEY_BITS-1:0]   cmp_key_i,
  input  logic [KEY_BITS-1:0]   wr_key_i,
  input  logic [VALUE_BITS-1:0] wr_value_i,
  input  logic [KEY_BITS-1:0]   nbr_key_i,
  input  logic [VALUE_BITS-1:0] nbr_value_i,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [VALUE_BITS-1:0] value_o,
  output logic                  hit_o
);

  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  hit_q;

  // Load a new entry or pull the neighbor's entry down
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      key_q   <= wr_key_i;
      value_q <= wr_value_i;
    end else if (ctrl_i.shift) begin
      key_q   <= nbr_key_i;
      value_q <= nbr_value_i;
    end
  end

  // Register the key match of an occupied slot when an item is accepted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      hit_q <= ctrl_i.live && (key_q == cmp_key_i);
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule

FILE: hdl/small_key_value_table.sv
// -----------------------------------------------------------------------------
// small_key_value_table: bounded key-value table in a row of cells
// Lookup, insert-if-absent, delete with order-keeping compaction, and clear.
//
//   channel  dir  tdata                          tuser
//   s_axis   in   key, value_in                  op
//   m_axis   out  value_out, entry_count         found, status, is_empty, is_full
//
// Each item goes through two steps: the accept edge registers the key compare in
// every cell, the second step resolves the match, loads or shifts the cells and
// fills the output register. No new item is taken until the last one executes.
// The second step waits while an unread result sits in the output register.
// Reset empties the table at once; cell contents are not cleared.
// -----------------------------------------------------------------------------
`include "small_key_value_table_macros.svh"

module small_key_value_table
  import skvt_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32,
  localparam int CntW      = $clog2(CAPACITY + 1),
  localparam int InDataW   = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OutDataW  = ((VALUE_BITS + CntW + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // key, value_in (from bit 0 up), zero padded
  input  logic [InDataW-1:0]  s_axis_tdata,
  // op
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // value_out, entry_count (from bit 0 up), zero padded
  output logic [OutDataW-1:0] m_axis_tdata,
  // found, status, is_empty, is_full (from bit 0 up)
  output logic [4:0]          m_axis_tuser
);

  localparam int IdxW = $clog2(CAPACITY);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  logic                  busy_q;
  skvt_op_e              op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [CntW-1:0]       count_q, count_d;

  logic                  out_valid_q;
  logic                  out_found_q;
  skvt_status_e          out_status_q;
  logic [VALUE_BITS-1:0] out_value_q;
  logic [CntW-1:0]       out_count_q;

  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_value;
  logic                  accept;
  logic                  exec;

  logic [CAPACITY-1:0]   hit;
  logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
  logic [VALUE_BITS-1:0] cell_value [CAPACITY];
  skvt_cell_ctrl_t       cell_ctrl  [CAPACITY];

  logic                  found;
  logic [IdxW-1:0]       slot;
  logic [VALUE_BITS-1:0] hit_value;
  logic                  full;
  logic                  do_insert;
  logic                  do_delete;
  skvt_status_e          status_d;

  assign in_key   = s_axis_tdata[KEY_BITS-1:0];
  assign in_value = s_axis_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];

  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign exec          = busy_q && (!out_valid_q || m_axis_tready);

  // Collapse the registered matches: at most one cell hits
  always_comb begin
    found     = 1'b0;
    slot      = '0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found     = found | hit[i];
      slot      = slot | (hit[i] ? IdxW'(i) : '0);
      hit_value = hit_value | (hit[i] ? cell_value[i] : '0);
    end
  end

  assign full      = (count_q == CapCnt);
  assign do_insert = exec && (op_q == OP_INSERT) && !found && !full;
  assign do_delete = exec && (op_q == OP_DELETE) && found;

  // Row of cells; on delete, cells at and above the hit slot pull their upper neighbor
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_BITS-1:0]   nbr_key;
    logic [VALUE_BITS-1:0] nbr_value;

    if (g == CAPACITY - 1) begin : g_top
      assign nbr_key   = '0;
      assign nbr_value = '0;
    end else begin : g_mid
      assign nbr_key   = cell_key[g+1];
      assign nbr_value = cell_value[g+1];
    end

    assign cell_ctrl[g].live    = CntW'(g) < count_q;
    assign cell_ctrl[g].capture = accept;
    assign cell_ctrl[g].shift   = do_delete && (IdxW'(g) >= slot);
    assign cell_ctrl[g].load    = do_insert && (CntW'(g) == count_q);

    skvt_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl[g]),
      .cmp_key_i   (in_key),
      .wr_key_i    (key_q),
      .wr_value_i  (value_q),
      .nbr_key_i   (nbr_key),
      .nbr_value_i (nbr_value),
      .key_o       (cell_key[g]),
      .value_o     (cell_value[g]),
      .hit_o       (hit[g])
    );
  end

  // Next entry count and result status
  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    unique case (op_q)
      OP_LOOKUP: begin
        if (!found) status_d = ST_ABSENT;
      end
      OP_INSERT: begin
        if (found) begin
          status_d = ST_PRESENT;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      OP_DELETE: begin
        if (found) begin
          count_d = count_q - CntW'(1);
        end else begin
          status_d = ST_ABSENT;
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  // Hold the request while the cells resolve it
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= skvt_op_e'(s_axis_tuser);
      key_q   <= in_key;
      value_q <= in_value;
    end
  end

  // Track the item in flight and the entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (exec) begin
        busy_q <= 1'b0;
      end
      if (exec) count_q <= count_d;
    end
  end

  // Output register: fill on execute, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_found_q  <= found && (op_q != OP_CLEAR);
      out_status_q <= status_d;
      out_value_q  <= (op_q == OP_LOOKUP && found) ? hit_value : '0;
      out_count_q  <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'({out_count_q, out_value_q});
  assign m_axis_tuser  = {out_count_q == CapCnt, out_count_q == '0,
                          out_status_q, out_found_q};

  // Checks
  `SKVT_ASSERT(a_count_bound, count_q <= CapCnt, "entry count above capacity")
  `SKVT_ASSERT(a_unique_hit, busy_q |-> $onehot0(hit), "key matched in more than one cell")
  `SKVT_ASSERT(a_idle_stable, !busy_q |=> $stable(count_q), "count changed with no item")
  `SKVT_ASSERT(a_exec_result, exec |=> m_axis_tvalid, "executed item left no result")

endmodule
